[src/pde_pkg.sv]
// ----------------------------------------------------------------------------
// pde_pkg
// Shared types, constants and the falling factorial function for the
// polynomial derivative evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pde_pkg;

    localparam int DATA_W      = 32;
    localparam int ORDER_W     = 3;
    localparam int FF_W        = 13;
    localparam int CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_DEGREE     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEFF_BASE = 4'd1;

    localparam logic [ORDER_W-1:0] DEGREE_RESET = 3'd5;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ovf;
    } chain_t;

    typedef struct packed {
        logic               load;
        logic               shift;
        logic [ORDER_W-1:0] k;
        logic [ORDER_W-1:0] d;
    } cell_ctrl_t;

    typedef struct packed {
        logic clear;
        logic mul;
        logic add;
    } horner_ctrl_t;

    // i! / (i-k)!, zero when k exceeds i.
    function automatic logic [FF_W-1:0] falling_fact(input int i, input logic [ORDER_W-1:0] k);
        int f;
        f = (i < int'(k)) ? 0 : 1;
        for (int j = 1; j <= 7; j++) begin
            if (j > i - int'(k) && j <= i) begin
                f = f * j;
            end
        end
        return FF_W'(f);
    endfunction

endpackage

`default_nettype wire

[src/pde_cell.sv]
// ----------------------------------------------------------------------------
// pde_cell
// One coefficient cell: holds a coefficient, scales it by the falling
// factorial on load and shifts its scaled value up the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pde_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            coeff_we,
    input  wire logic [pde_pkg::DATA_W-1:0]      coeff_data,
    input  wire pde_pkg::cell_ctrl_t             ctrl,
    input  wire pde_pkg::chain_t                 prev,
    output pde_pkg::chain_t                      link_out
);
    import pde_pkg::*;

    logic signed [DATA_W-1:0]    coeff_reg, coeff_next;
    chain_t                      link_reg, link_next;
    logic [FF_W-1:0]             ff;
    logic signed [DATA_W+FF_W:0] prod;
    logic                        in_range;
    logic                        fits;
    chain_t                      scaled;

    assign ff       = falling_fact(INDEX, ctrl.k);
    assign prod     = coeff_reg * $signed({1'b0, ff});
    assign in_range = (ORDER_W'(INDEX) >= ctrl.k) && (ORDER_W'(INDEX) <= ctrl.d);
    assign fits     = (&prod[DATA_W+FF_W:DATA_W-1]) | ~(|prod[DATA_W+FF_W:DATA_W-1]);

    always_comb begin
        scaled = '0;
        if (in_range) begin
            if (fits) begin
                scaled.val = prod[DATA_W-1:0];
            end else if (prod[DATA_W+FF_W]) begin
                scaled.val = {1'b1, {(DATA_W-1){1'b0}}};
                scaled.ovf = 1'b1;
            end else begin
                scaled.val = {1'b0, {(DATA_W-1){1'b1}}};
                scaled.ovf = 1'b1;
            end
        end
    end

    always_comb begin
        coeff_next = coeff_we ? $signed(coeff_data) : coeff_reg;
        link_next  = link_reg;
        if (ctrl.load) begin
            link_next = scaled;
        end else if (ctrl.shift) begin
            link_next = prev;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= '0;
        end else begin
            coeff_reg <= coeff_next;
        end
    end

    always_ff @(posedge aclk) begin
        link_reg <= link_next;
    end

    assign link_out = link_reg;

endmodule

`default_nettype wire

[src/pde_horner.sv]
// ----------------------------------------------------------------------------
// pde_horner
// Horner accumulator: registered multiply by the point, then rounding,
// saturation and addition of the coefficient at the head of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module pde_horner #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               aclk,
    input  wire pde_pkg::horner_ctrl_t              ctrl,
    input  wire logic signed [pde_pkg::DATA_W-1:0]  z_in,
    input  wire pde_pkg::chain_t                    head,
    output logic signed [pde_pkg::DATA_W-1:0]       sum_out,
    output logic                                    ovf_out
);
    import pde_pkg::*;

    localparam int PROD_W = 2 * DATA_W;

    logic signed [DATA_W-1:0] z_reg, z_next;
    logic signed [DATA_W-1:0] sum_reg, sum_next;
    logic                     ovf_reg, ovf_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] quo;
    logic                     quo_fits;
    logic signed [DATA_W-1:0] quo_sat;
    logic signed [DATA_W:0]   add;
    logic                     add_fits;
    logic signed [DATA_W-1:0] add_sat;

    assign prod_next = sum_reg * z_reg;
    assign rnd       = prod_reg + (PROD_W'(1) <<< (FRAC_BITS - 1));
    assign quo       = rnd >>> FRAC_BITS;
    assign quo_fits  = (&quo[PROD_W-1:DATA_W-1]) | ~(|quo[PROD_W-1:DATA_W-1]);

    always_comb begin
        if (quo_fits) begin
            quo_sat = quo[DATA_W-1:0];
        end else if (quo[PROD_W-1]) begin
            quo_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            quo_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign add      = {quo_sat[DATA_W-1], quo_sat} + {head.val[DATA_W-1], head.val};
    assign add_fits = (add[DATA_W] == add[DATA_W-1]);

    always_comb begin
        if (add_fits) begin
            add_sat = add[DATA_W-1:0];
        end else if (add[DATA_W]) begin
            add_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            add_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_comb begin
        z_next   = z_reg;
        sum_next = sum_reg;
        ovf_next = ovf_reg;
        if (ctrl.clear) begin
            z_next   = z_in;
            sum_next = '0;
            ovf_next = 1'b0;
        end else if (ctrl.add) begin
            sum_next = add_sat;
            ovf_next = ovf_reg | ~quo_fits | ~add_fits | head.ovf;
        end
    end

    always_ff @(posedge aclk) begin
        z_reg    <= z_next;
        sum_reg  <= sum_next;
        ovf_reg  <= ovf_next;
        if (ctrl.mul) begin
            prod_reg <= prod_next;
        end
    end

    assign sum_out = sum_reg;
    assign ovf_out = ovf_reg;

endmodule

`default_nettype wire

[src/polynomial_derivative_eval.sv]
// ----------------------------------------------------------------------------
// polynomial_derivative_eval
// k-th derivative of a polynomial at a point, Horner's rule over a chain
// of coefficient cells, signed fixed point with saturation.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_tvalid / s_tready  s_tdata: point, deriv_order
//  m_       out        m_tvalid / m_tready  m_tdata: value; m_tuser: overflow
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  An item passes the shared multiplier (S_MUL) and adder (S_ADD) once per
//  coefficient from index MAX_DEGREE down to k before S_DONE loads the output
//  register, or goes straight to S_DONE when k exceeds the degree in use.
//  One item is in work at a time; the output register holds a result while
//  the next item is taken. A stall on m_tready holds a finished item.
//  Reset is synchronous and active low and restores degree 5, zero coefficients.
//
`default_nettype none

module polynomial_derivative_eval #(
    parameter int MAX_DEGREE = 5,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [39:0]                         s_tdata,   // point[31:0], deriv_order[34:32]
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [pde_pkg::DATA_W-1:0]               m_tdata,   // value[31:0]
    output logic [0:0]                               m_tuser,   // overflow[0]
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pde_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [pde_pkg::DATA_W-1:0]          cfg_data
);
    import pde_pkg::*;

    localparam int CNT_W = $clog2(MAX_DEGREE + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ADD  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [ORDER_W-1:0]       degree_reg, degree_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]        out_data_reg, out_data_next;
    logic                     out_ovf_reg, out_ovf_next;

    logic                     s_xfer;
    logic [ORDER_W-1:0]       in_k;
    logic [ORDER_W-1:0]       d_use;
    logic [ORDER_W:0]         steps;
    cell_ctrl_t               cctrl;
    horner_ctrl_t             hctrl;
    chain_t                   chain_zero;
    chain_t                   links [0:MAX_DEGREE];
    logic signed [DATA_W-1:0] sum;
    logic                     ovf;

    assign cfg_ready  = 1'b1;
    assign s_tready   = (state_reg == S_IDLE);
    assign s_xfer     = s_tvalid & s_tready;
    assign in_k       = s_tdata[DATA_W+ORDER_W-1:DATA_W];
    assign d_use      = (degree_reg > ORDER_W'(MAX_DEGREE)) ? ORDER_W'(MAX_DEGREE) : degree_reg;
    assign steps      = (ORDER_W+1)'(MAX_DEGREE) - {1'b0, in_k};
    assign chain_zero = '0;

    assign cctrl.load  = s_xfer;
    assign cctrl.shift = (state_reg == S_ADD);
    assign cctrl.k     = in_k;
    assign cctrl.d     = d_use;

    assign hctrl.clear = s_xfer;
    assign hctrl.mul   = (state_reg == S_MUL);
    assign hctrl.add   = (state_reg == S_ADD);

    for (genvar i = 0; i <= MAX_DEGREE; i++) begin : g_cell
        pde_cell #(
            .INDEX(i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .coeff_we  (cfg_valid && (cfg_index == REG_COEFF_BASE + CFG_INDEX_W'(i))),
            .coeff_data(cfg_data),
            .ctrl      (cctrl),
            .prev      ((i == 0) ? chain_zero : links[(i == 0) ? 0 : i - 1]),
            .link_out  (links[i])
        );
    end

    pde_horner #(
        .FRAC_BITS(FRAC_BITS)
    ) u_horner (
        .aclk   (aclk),
        .ctrl   (hctrl),
        .z_in   ($signed(s_tdata[DATA_W-1:0])),
        .head   (links[MAX_DEGREE]),
        .sum_out(sum),
        .ovf_out(ovf)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        degree_next    = degree_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_ovf_next   = out_ovf_reg;

        if (cfg_valid && cfg_index == REG_DEGREE) begin
            degree_next = cfg_data[ORDER_W-1:0];
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    cnt_next = steps[CNT_W-1:0];
                    if (in_k > d_use) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                state_next = S_ADD;
            end
            S_ADD: begin
                if (cnt_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_MUL;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = sum;
                    out_ovf_next   = ovf;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            degree_reg    <= DEGREE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            degree_reg    <= degree_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_ovf_reg;

endmodule

`default_nettype wire
